[design/touch_spring_scroll_assert.svh]
// assertion macros used by the checker file
`ifndef TOUCH_SPRING_SCROLL_ASSERT_SVH
`define TOUCH_SPRING_SCROLL_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TSS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch_spring_scroll: assertion failed");

// antecedent implies consequent in the next cycle
`define TSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch_spring_scroll: assertion failed");

`endif

[design/tss_pkg.sv]
`default_nettype none

package tss_pkg;

    // event kinds
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_DRAG    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_TICK    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_VIEW_HEIGHT    = 2'd0;
    localparam logic [1:0] CFG_CONTENT_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SPRING_GAIN    = 2'd2;
    localparam logic [1:0] CFG_DAMPING_GAIN   = 2'd3;

    // configuration reset values
    localparam logic [15:0] VIEW_HEIGHT_RST    = 16'd480;
    localparam logic [15:0] CONTENT_HEIGHT_RST = 16'd0;
    localparam logic [15:0] SPRING_GAIN_RST    = 16'd7680;
    localparam logic [15:0] DAMPING_GAIN_RST   = 16'd2560;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    // acceleration accumulator (Q.24)
    localparam int ACC_W   = 50;
    // widest sum fed to the saturation
    localparam int SUM_W   = 44;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         pointer_id;
        logic signed [15:0] touch_y;
        logic [15:0]        dt;
    } evt_t;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
    } res_t;

    // touch tracking state
    typedef struct packed {
        logic               active;
        logic [7:0]         owner_id;
        logic signed [15:0] press_y;
        logic signed [31:0] grab;
        logic signed [31:0] target;
    } touch_t;

    // clamp to the signed Q16.16 range
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7FFF_FFFF);
        lo = -hi - SUM_W'(1);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

`default_nettype wire

[design/tss_mul.sv]
`default_nettype none

module tss_mul (
    input  wire logic signed [tss_pkg::MUL_A_W-1:0] a,
    input  wire logic signed [tss_pkg::MUL_B_W-1:0] b,
    output logic signed [tss_pkg::MUL_P_W-1:0]      p
);
    import tss_pkg::*;

    // signed product, full width
    always_comb
    begin
        p = MUL_P_W'(a) * MUL_P_W'(b);
    end

endmodule

`default_nettype wire

[design/tss_touch.sv]
`default_nettype none

module tss_touch (
    input  wire tss_pkg::evt_t   evt,
    input  wire tss_pkg::touch_t touch_cur,
    input  wire logic [15:0]     view_height,
    input  wire logic [15:0]     content_height,
    output tss_pkg::touch_t      touch_next,
    output logic                 accepted
);
    import tss_pkg::*;

    logic signed [16:0]      dy;
    logic signed [SUM_W-1:0] moved_sum;
    logic signed [31:0]      moved;
    logic signed [16:0]      low_px;
    logic signed [32:0]      low_q;
    logic                    owner_hit;

    always_comb
    begin
        owner_hit  = touch_cur.active && (touch_cur.owner_id == evt.pointer_id);
        dy         = 17'(evt.touch_y) - 17'(touch_cur.press_y);
        // grab position plus the y movement, in Q16.16
        moved_sum  = SUM_W'(touch_cur.grab) + SUM_W'($signed({dy, 16'h0000}));
        moved      = sat32(moved_sum);
        // lowest allowed offset: view minus content
        low_px     = $signed({1'b0, view_height}) - $signed({1'b0, content_height});
        low_q      = {low_px, 16'h0000};

        touch_next = touch_cur;
        accepted   = 1'b0;
        case (evt.kind)
            KIND_PRESS:
            begin
                touch_next.active   = 1'b1;
                touch_next.owner_id = evt.pointer_id;
                touch_next.press_y  = evt.touch_y;
                touch_next.grab     = touch_cur.target;
                accepted            = 1'b1;
            end
            KIND_DRAG:
            begin
                if (owner_hit)
                begin
                    touch_next.target = moved;
                    accepted          = 1'b1;
                end
            end
            KIND_RELEASE:
            begin
                if (owner_hit)
                begin
                    // clamp into the scrollable range
                    if (content_height < view_height)
                        touch_next.target = '0;
                    else if (moved > 32'sd0)
                        touch_next.target = '0;
                    else if (33'(moved) < low_q)
                        touch_next.target = sat32(SUM_W'(low_q));
                    else
                        touch_next.target = moved;
                    touch_next.active = 1'b0;
                    accepted          = 1'b1;
                end
            end
            default:
            begin
                touch_next = touch_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/touch_spring_scroll.sv]
// touch_spring_scroll: inertial touch scrolling with a spring-damper
//
// evt channel (evt_valid / evt_stall / evt) carries press, drag, release
// and tick items; res channel (res_valid / res_stall / res) returns one
// result item per event with the accept flag, position and velocity.
// cfg_we / cfg_index / cfg_data write the four 16 bit registers; the user
// must write them only while the block is idle; the block does not enforce it.
// A press, drag or release is handled in the accept cycle; its result is
// valid on the next cycle, one item per cycle while no result is stalled.
// A tick runs four passes through one shared 42x17 multiplier (spring,
// damping, velocity update, position update), then ST_DONE loads the
// result register; no new item is taken until that result is loaded.
// evt_stall is high while a tick is being processed, and while a result
// is waiting under res_stall; a stalled result holds its value.
// Reset clears the touch state, position and velocity, loads the register
// defaults and leaves no result pending.
`default_nettype none

module touch_spring_scroll (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          evt_valid,
    output logic               evt_stall,
    input  wire tss_pkg::evt_t evt,
    output logic               res_valid,
    input  wire logic          res_stall,
    output tss_pkg::res_t      res,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);
    import tss_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL_K = 6'b000010,
        ST_MUL_D = 6'b000100,
        ST_MUL_A = 6'b001000,
        ST_MUL_V = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [15:0]             view_reg, content_reg, spring_reg, damping_reg;
    touch_t                  touch_reg, touch_next;
    logic signed [31:0]      pos_reg, pos_next;
    logic signed [31:0]      vel_reg, vel_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [15:0]             dt_reg, dt_next;
    res_t                    res_reg, res_next;
    logic                    res_valid_reg, res_valid_next;

    touch_t                  touch_upd;
    logic                    touch_acc;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [32:0]      diff;
    logic                    slot_free;
    logic                    evt_take;

    // touch event logic
    tss_touch u_touch (
        .evt            (evt),
        .touch_cur      (touch_reg),
        .view_height    (view_reg),
        .content_height (content_reg),
        .touch_next     (touch_upd),
        .accepted       (touch_acc)
    );

    // shared multiplier
    tss_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    assign slot_free = !res_valid_reg || !res_stall;
    assign evt_stall = (state_reg != ST_IDLE) || !slot_free;
    assign evt_take  = evt_valid && !evt_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // multiplier operand select
    always_comb
    begin
        diff  = 33'(touch_reg.target) - 33'(pos_reg);
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_K:
            begin
                mul_a = MUL_A_W'(diff);
                mul_b = $signed({1'b0, spring_reg});
            end
            ST_MUL_D:
            begin
                mul_a = MUL_A_W'(vel_reg);
                mul_b = $signed({1'b0, damping_reg});
            end
            ST_MUL_A:
            begin
                mul_a = acc_reg[ACC_W-1:8];
                mul_b = $signed({1'b0, dt_reg});
            end
            ST_MUL_V:
            begin
                mul_a = MUL_A_W'(vel_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        touch_next     = touch_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        acc_next       = acc_reg;
        dt_next        = dt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (evt_take)
                begin
                    if (evt.kind == KIND_TICK)
                    begin
                        dt_next    = evt.dt;
                        state_next = ST_MUL_K;
                    end
                    else
                    begin
                        touch_next        = touch_upd;
                        res_next.accepted = touch_acc;
                        res_next.position = pos_reg;
                        res_next.velocity = vel_reg;
                        res_valid_next    = 1'b1;
                    end
                end
            end
            ST_MUL_K:
            begin
                acc_next   = mul_p[ACC_W-1:0];
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                acc_next   = acc_reg - mul_p[ACC_W-1:0];
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                vel_next   = sat32(SUM_W'(vel_reg) + SUM_W'($signed(mul_p[MUL_P_W-1:16])));
                state_next = ST_MUL_V;
            end
            ST_MUL_V:
            begin
                pos_next   = sat32(SUM_W'(pos_reg) + SUM_W'($signed(mul_p[MUL_P_W-1:16])));
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    res_next.accepted = 1'b0;
                    res_next.position = pos_reg;
                    res_next.velocity = vel_reg;
                    res_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and scroll state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            touch_reg     <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            view_reg      <= VIEW_HEIGHT_RST;
            content_reg   <= CONTENT_HEIGHT_RST;
            spring_reg    <= SPRING_GAIN_RST;
            damping_reg   <= DAMPING_GAIN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            touch_reg     <= touch_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_VIEW_HEIGHT:    view_reg    <= cfg_data;
                    CFG_CONTENT_HEIGHT: content_reg <= cfg_data;
                    CFG_SPRING_GAIN:    spring_reg  <= cfg_data;
                    CFG_DAMPING_GAIN:   damping_reg <= cfg_data;
                    default:            view_reg    <= view_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        dt_reg  <= dt_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

[design/tss_checker.sv]
`default_nettype none

`include "touch_spring_scroll_assert.svh"

module tss_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          evt_valid,
    input wire logic          evt_stall,
    input wire tss_pkg::evt_t evt,
    input wire logic          res_valid,
    input wire logic          res_stall,
    input wire tss_pkg::res_t res
);
    import tss_pkg::*;

    // a waiting result keeps its valid
    `TSS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)

    // no new item while a result is blocked
    `TSS_ASSERT_SAME(a_no_take_blocked, res_valid && res_stall, evt_stall)

    // a tick occupies the multiplier on the following cycle
    `TSS_ASSERT_NEXT(a_tick_busy, evt_valid && !evt_stall && evt.kind == KIND_TICK, evt_stall)

    // a press reports accepted on the next cycle
    `TSS_ASSERT_NEXT(a_press_res, evt_valid && !evt_stall && evt.kind == KIND_PRESS,
                     res_valid && res.accepted)

endmodule

bind touch_spring_scroll tss_checker u_tss_checker (.*);

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
    import tss_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_ITEMS = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        evt_valid = 1'b0;
    logic        evt_stall;
    evt_t        evt = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_VIEW_HEIGHT;
    logic [15:0] cfg_data = '0;

    // scoreboard
    res_t pending_results[$];
    int   err_count = 0;
    int   n_sent = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    bit   tx_gaps_on = 1'b1;
    bit   rx_stall_on = 1'b1;

    // predictor copy of registers and state
    logic [15:0]        view_m = VIEW_HEIGHT_RST;
    logic [15:0]        content_m = CONTENT_HEIGHT_RST;
    logic [15:0]        spring_m = SPRING_GAIN_RST;
    logic [15:0]        damp_m = DAMPING_GAIN_RST;
    logic               touch_on_m = 1'b0;
    logic [7:0]         owner_m = '0;
    logic signed [15:0] press_y_m = '0;
    logic signed [31:0] grab_m = '0;
    logic signed [31:0] target_m = '0;
    logic signed [31:0] pos_m = '0;
    logic signed [31:0] vel_m = '0;

    touch_spring_scroll i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // clamp a wide value into signed Q16.16
    function automatic logic signed [31:0] q_sat(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // advance the predicted scroll state by one item, return its result
    function automatic res_t scroll_predict(evt_t e);
        res_t    r;
        longint  a24;
        longint  a16;
        longint  dtl;
        longint  lo;
        r.accepted = 1'b0;
        case (e.kind)
            KIND_PRESS:
            begin
                touch_on_m = 1'b1;
                owner_m = e.pointer_id;
                press_y_m = $signed(e.touch_y);
                grab_m = target_m;
                r.accepted = 1'b1;
            end
            KIND_DRAG, KIND_RELEASE:
            begin
                if (touch_on_m && owner_m == e.pointer_id)
                begin
                    target_m = q_sat(longint'(grab_m) +
                        (longint'($signed(e.touch_y)) - longint'(press_y_m)) * 64'sd65536);
                    if (e.kind == KIND_RELEASE)
                    begin
                        if (content_m < view_m)
                            target_m = '0;
                        else if (target_m > 0)
                            target_m = '0;
                        else
                        begin
                            lo = (longint'(view_m) - longint'(content_m)) * 64'sd65536;
                            if (longint'(target_m) < lo)
                                target_m = q_sat(lo);
                        end
                        touch_on_m = 1'b0;
                    end
                    r.accepted = 1'b1;
                end
            end
            default:
            begin
                // one euler step, velocity first then position with the new velocity
                a24 = longint'(spring_m) * (longint'(target_m) - longint'(pos_m))
                    - longint'(damp_m) * longint'(vel_m);
                a16 = a24 >>> 8;
                dtl = longint'(e.dt);
                vel_m = q_sat(longint'(vel_m) + ((a16 * dtl) >>> 16));
                pos_m = q_sat(longint'(pos_m) + ((longint'(vel_m) * dtl) >>> 16));
            end
        endcase
        r.position = pos_m;
        r.velocity = vel_m;
        return r;
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic evt_t make_event(logic [1:0] k, logic [7:0] p, int y, logic [15:0] d);
        evt_t e;
        e.kind = k;
        e.pointer_id = p;
        e.touch_y = y[15:0];
        e.dt = d;
        return e;
    endfunction

    function automatic int clamp_y(int y);
        if (y > 32767)
            return 32767;
        else if (y < -32768)
            return -32768;
        else
            return y;
    endfunction

    // send one item and record its expected result once accepted
    task automatic send_event(evt_t e);
        int gap;
        gap = tx_gaps_on ? idle_len() : 0;
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt <= e;
        evt_valid <= 1'b1;
        do
            @(posedge clk);
        while (evt_stall);
        pending_results.push_back(scroll_predict(e));
        n_sent++;
    endtask

    // hold off the sender until every expected result has come back
    task automatic drain_results();
        evt_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all four registers, block must be idle
    task automatic apply_config(logic [15:0] v, logic [15:0] c, logic [15:0] s,
                                logic [15:0] d);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= CFG_VIEW_HEIGHT;
        cfg_data <= v;
        @(posedge clk);
        cfg_index <= CFG_CONTENT_HEIGHT;
        cfg_data <= c;
        @(posedge clk);
        cfg_index <= CFG_SPRING_GAIN;
        cfg_data <= s;
        @(posedge clk);
        cfg_index <= CFG_DAMPING_GAIN;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        view_m = v;
        content_m = c;
        spring_m = s;
        damp_m = d;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_reg(int lo);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'(lo);
        else if (r == 1)
            return 16'hFFFF;
        else if (r < 4)
            return 16'($urandom_range(lo, 65535));
        else
            return 16'($urandom_range(lo, 4096));
    endfunction

    task automatic random_config();
        logic [15:0] v;
        int          c;
        v = pick_reg(1);
        if ($urandom_range(0, 3) == 0)
            c = pick_reg(0);
        else
            c = int'(v) + $urandom_range(0, 3000) - 500;
        if (c < 0)
            c = 0;
        if (c > 65535)
            c = 65535;
        apply_config(v, c[15:0], pick_reg(0), pick_reg(0));
    endtask

    function automatic logic [15:0] random_dt();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom_range(0, 65535));
        else
            return 16'($urandom_range(0, 2200));
    endfunction

    function automatic evt_t random_item();
        return make_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          int'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endfunction

    // press, drags, release, then a few ticks; sometimes broken on purpose
    task automatic run_gesture();
        logic [7:0] pid;
        int         y;
        int         n;
        pid = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            y = $urandom_range(0, 65535) - 32768;
        else
            y = $urandom_range(0, 1000);
        send_event(make_event(KIND_PRESS, pid, y, 16'($urandom_range(0, 65535))));
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                send_event(make_event(KIND_DRAG, 8'(pid + $urandom_range(1, 255)), y, 16'd0));
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    y = $urandom_range(0, 65535) - 32768;
                else
                    y = clamp_y(y + $urandom_range(0, 600) - 300);
                send_event(make_event(KIND_DRAG, pid, y, 16'($urandom_range(0, 65535))));
            end
            if ($urandom_range(0, 4) == 0)
                send_event(make_event(KIND_TICK, 8'($urandom_range(0, 255)),
                                      int'($urandom_range(0, 65535)), random_dt()));
        end
        n = $urandom_range(0, 19);
        if (n < 2)
            send_event(make_event(KIND_RELEASE, pid ^ 8'h5A, y, 16'd0));
        else if (n > 2)
            send_event(make_event(KIND_RELEASE, pid, clamp_y(y + $urandom_range(0, 400) - 200),
                                  16'($urandom_range(0, 65535))));
        n = $urandom_range(1, 8);
        repeat (n)
            send_event(make_event(KIND_TICK, 8'($urandom_range(0, 255)),
                                  int'($urandom_range(0, 65535)), random_dt()));
    endtask

    // ownership, takeover, ignored events and release clamping
    task automatic test_touch_corners();
        send_event(make_event(KIND_TICK, 8'd0, 0, 16'd0));
        send_event(make_event(KIND_DRAG, 8'd0, 100, 16'd0));
        send_event(make_event(KIND_RELEASE, 8'd0, 100, 16'd0));
        send_event(make_event(KIND_PRESS, 8'd0, -32768, 16'd0));
        send_event(make_event(KIND_DRAG, 8'd1, 0, 16'd0));
        send_event(make_event(KIND_DRAG, 8'd0, 32767, 16'd0));
        send_event(make_event(KIND_TICK, 8'd0, 0, 16'hFFFF));
        send_event(make_event(KIND_TICK, 8'd0, 0, 16'd1));
        send_event(make_event(KIND_PRESS, 8'd255, 32767, 16'd0));
        send_event(make_event(KIND_DRAG, 8'd255, 32767, 16'd0));
        send_event(make_event(KIND_DRAG, 8'd0, 0, 16'd0));
        send_event(make_event(KIND_DRAG, 8'd255, -32768, 16'd0));
        send_event(make_event(KIND_RELEASE, 8'd255, -32768, 16'd0));
        send_event(make_event(KIND_RELEASE, 8'd255, 0, 16'd0));
        send_event(make_event(KIND_TICK, 8'd0, 0, 16'd1092));
        send_event(make_event(KIND_TICK, 8'd0, 0, 16'd0));
        // content taller than view
        apply_config(16'd100, 16'd1000, SPRING_GAIN_RST, DAMPING_GAIN_RST);
        send_event(make_event(KIND_PRESS, 8'd7, 0, 16'd0));
        send_event(make_event(KIND_RELEASE, 8'd7, 50, 16'd0));
        send_event(make_event(KIND_PRESS, 8'd7, 0, 16'd0));
        send_event(make_event(KIND_RELEASE, 8'd7, -2000, 16'd0));
        send_event(make_event(KIND_PRESS, 8'd8, 100, 16'd0));
        send_event(make_event(KIND_RELEASE, 8'd8, -300, 16'd0));
        repeat (3)
            send_event(make_event(KIND_TICK, 8'd0, 0, 16'd1092));
    endtask

    // target, position and velocity driven into saturation
    task automatic test_saturation();
        apply_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
        send_event(make_event(KIND_PRESS, 8'd3, 32767, 16'd0));
        send_event(make_event(KIND_DRAG, 8'd3, -32768, 16'd0));
        send_event(make_event(KIND_PRESS, 8'd3, 32767, 16'd0));
        send_event(make_event(KIND_RELEASE, 8'd3, -32768, 16'd0));
        repeat (4)
            send_event(make_event(KIND_TICK, 8'd0, 0, 16'hFFFF));
        send_event(make_event(KIND_PRESS, 8'd4, -32768, 16'd0));
        send_event(make_event(KIND_DRAG, 8'd4, 32767, 16'd0));
        send_event(make_event(KIND_PRESS, 8'd4, -32768, 16'd0));
        send_event(make_event(KIND_DRAG, 8'd4, 32767, 16'd0));
        repeat (3)
            send_event(make_event(KIND_TICK, 8'd0, 0, 16'hFFFF));
        apply_config(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        send_event(make_event(KIND_RELEASE, 8'd4, 0, 16'd0));
        repeat (2)
            send_event(make_event(KIND_TICK, 8'd0, 0, 16'hFFFF));
        apply_config(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        repeat (3)
            send_event(make_event(KIND_TICK, 8'd0, 0, 16'hFFFF));
    endtask

    // mostly well-formed gestures under several register settings
    task automatic test_random_scrolling();
        int stop_at;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                apply_config(VIEW_HEIGHT_RST, 16'd2000, SPRING_GAIN_RST, DAMPING_GAIN_RST);
            else
                random_config();
            tx_gaps_on = (phase % 3) != 1;
            rx_stall_on = (phase % 3) != 2;
            stop_at = n_sent + PHASE_ITEMS;
            while (n_sent < stop_at)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_event(random_item());
                else
                    run_gesture();
                if (phase == 2 && n_sent >= stop_at - PHASE_ITEMS / 2 &&
                    n_sent < stop_at - PHASE_ITEMS / 2 + 4)
                    drain_results();
            end
        end
        tx_gaps_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // fully random items
    task automatic test_random_noise();
        random_config();
        repeat (PHASE_ITEMS)
            send_event(random_item());
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (rx_stall_on && $urandom_range(0, 99) < 30)
        begin
            stall_left = idle_len();
            res_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
        else
            res_stall <= 1'b0;
    end

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item: position %0d velocity %0d",
                       res.position, res.velocity);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.accepted !== want.accepted)
                begin
                    $error("accepted: expected %0d, actual %0d", want.accepted, res.accepted);
                    err_count++;
                end
                if (res.position !== want.position)
                begin
                    $error("position: expected %0d, actual %0d", want.position, res.position);
                    err_count++;
                end
                if (res.velocity !== want.velocity)
                begin
                    $error("velocity: expected %0d, actual %0d", want.velocity, res.velocity);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_valid && !evt_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_touch_corners();
        test_saturation();
        test_random_scrolling();
        test_random_noise();
        drain_results();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+design
design/tss_pkg.sv
design/tss_mul.sv
design/tss_touch.sv
design/touch_spring_scroll.sv
design/tss_checker.sv
bench/tb.sv
